/* rtl/tile_label_histogram_scorer_assert.svh */
// Assertion macros for the tile label histogram scorer checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef TILE_LABEL_HISTOGRAM_SCORER_ASSERT_SVH
`define TILE_LABEL_HISTOGRAM_SCORER_ASSERT_SVH

// same-cycle implication, ignored during reset
`define THLS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored during reset
`define THLS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define THLS_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/thls_pkg.sv */
// Shared constants for the tile label histogram scorer.
// No dependencies.
package thls_pkg;

  localparam int LABEL_W    = 8;
  localparam int POS_W      = 16;
  localparam int EDGE_W     = 10;
  localparam int LIMIT_W    = 17;
  localparam int CLASS_W    = 3;
  localparam int SHARE_W    = 17;
  localparam int COUNT_W    = 19;
  localparam int AREA_W     = 2 * EDGE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_EDGE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_LIMIT      = 3'd5;

endpackage

/* rtl/thls_if.sv */
// Valid/ready channel interfaces: pixel labels in, tile results out.
// Depends on thls_pkg.
interface thls_in_if;
  import thls_pkg::*;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label;
  modport source (output valid, output label, input ready);
  modport sink   (input valid, input label, output ready);
endinterface

interface thls_out_if;
  import thls_pkg::*;
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   origin_x;
  logic [POS_W-1:0]   origin_y;
  logic [CLASS_W-1:0] tile_class;
  logic [SHARE_W-1:0] share;
  modport source (output valid, output origin_x, output origin_y,
                  output tile_class, output share, input ready);
  modport sink   (input valid, input origin_x, input origin_y,
                  input tile_class, input share, output ready);
endinterface

/* rtl/thls_count_ram.sv */
// Tile histogram store: one word of label counters per tile slot.
// Synchronous, registered read. No dependencies.
module thls_count_ram #(
  parameter int DEPTH  = 512,
  parameter int WORD_W = 114,
  parameter int AW     = 9
) (
  input  logic              clk,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata
);
  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/thls_share_div.sv */
// Share divider: floor(count * 65536 / area), one quotient bit per cycle.
// Needs count <= area. Depends on thls_pkg.
module thls_share_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [thls_pkg::COUNT_W-1:0]    count,
  input  logic [thls_pkg::AREA_W-1:0]     area,
  output logic                            done,
  output logic [thls_pkg::SHARE_W-1:0]    quotient
);
  import thls_pkg::*;

  localparam int REM_W  = AREA_W + 1;
  localparam int STEP_W = $clog2(SHARE_W + 1);

  logic [REM_W-1:0]  rem;
  logic [AREA_W-1:0] divisor;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [REM_W-1:0]  trial;
  logic              take;

  // first step tests the integer bit, the rest shift in fraction bits
  assign trial = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= REM_W'(count);
        divisor  <= area;
        quotient <= '0;
      end else if (busy) begin
        rem      <= take ? trial - {1'b0, divisor} : trial;
        quotient <= {quotient[SHARE_W-2:0], take};
        step     <= step + 1'b1;
        if (step == STEP_W'(SHARE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/tile_label_histogram_scorer.sv */
// Tile label histogram scorer.
// pixel (sink): one mask label per item, raster order, row by row.
// result (source): tile origin, chosen class and Q1.16 share, at most one
//   item per pixel, issued when a tile's bottom-right pixel is processed.
// Config: cfg_we/cfg_index/cfg_data, write only while idle; any write of a
//   listed register restarts the image at pixel (0,0).
// Per pixel the walker visits every tile row and column that may hold it;
//   each tile takes a read (S_COL) and a modify/write (S_RD) on the count
//   memory, whose read and write share one address, and each tile row a
//   visit of S_ROW, plus accept (S_IDLE) and finish (S_FINISH). A scored
//   tile adds a divider run for the background share and, unless the
//   background wins or no class is counted, one more for the winning class
//   share, and when a share passes its limit loads the output register in S_EMIT.
// The next pixel is taken only after the previous one is fully done.
// A held result stalls the block only when a new result is ready to load.
// Reset: registers return to defaults, position to (0,0), result invalid.
//   The count memory needs no clearing: every tile is zeroed at its own
//   top-left pixel before it is ever scored.
module tile_label_histogram_scorer #(
  parameter int MAX_TILE_EDGE        = 512,
  parameter int MAX_TILES_ACROSS     = 128,
  parameter int MAX_ACTIVE_TILE_ROWS = 4,
  parameter int NUM_LABELS           = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  thls_in_if.sink                           pixel,
  thls_out_if.source                        result,
  input  logic                              cfg_we,
  input  logic [thls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [thls_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import thls_pkg::*;

  localparam int DEPTH  = MAX_TILES_ACROSS * MAX_ACTIVE_TILE_ROWS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TXW    = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int SW     = (MAX_ACTIVE_TILE_ROWS > 1) ? $clog2(MAX_ACTIVE_TILE_ROWS) : 1;
  localparam int LW     = $clog2(NUM_LABELS);
  localparam int WORD_W = NUM_LABELS * COUNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW    = 3'd1;
  localparam logic [2:0] S_COL    = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_DIV0   = 3'd5;
  localparam logic [2:0] S_DIV1   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  // configuration
  logic [POS_W-1:0]   image_width, image_height;
  logic [EDGE_W-1:0]  tile_edge, tile_step;
  logic [LIMIT_W-1:0] background_limit, class_limit;

  logic [POS_W-1:0]  w, h;
  logic [EDGE_W-1:0] e1, e, s;
  logic              all_rows;

  assign w  = (image_width == '0) ? POS_W'(1) : image_width;
  assign h  = (image_height == '0) ? POS_W'(1) : image_height;
  assign e1 = (tile_edge == '0) ? EDGE_W'(1) : tile_edge;
  assign e  = (int'(e1) > MAX_TILE_EDGE) ? EDGE_W'(MAX_TILE_EDGE) : e1;
  assign s  = (tile_step == '0) ? EDGE_W'(1) : tile_step;
  assign all_rows = 32'(e) <= 32'(MAX_ACTIVE_TILE_ROWS) * 32'(s);

  // scan position and its tile decomposition
  logic [POS_W-1:0]  pos_x, pos_y, base_x, base_y, q_x, q_y;
  logic [EDGE_W-1:0] rem_x, rem_y;
  logic [SW-1:0]     slot_y;

  // per-item walker
  logic [2:0]         state;
  logic [LABEL_W-1:0] cur_label;
  logic [POS_W-1:0]   px, py, lat_qx, lat_bx, tx, ty, tx_x0, ty_y0;
  logic [SW-1:0]      slot;
  logic [AREA_W-1:0]  area;
  logic               pend;
  logic [POS_W-1:0]   sc_x0, sc_y0;
  logic [COUNT_W-1:0] sc_counts [NUM_LABELS];

  logic [CLASS_W-1:0] hold_cls;
  logic [SHARE_W-1:0] hold_share;

  // walker conditions
  logic [POS_W-1:0]   dx, dy;
  logic               row_in, row_ok, col_in, col_ok, first_px, last_px;
  logic               label_hit;
  logic [COUNT_W-1:0] cnt_new [NUM_LABELS];
  logic [WORD_W-1:0]  rdata, wdata;
  logic [AW-1:0]      addr;
  logic               mem_re, mem_we;

  assign dx = px - tx_x0;
  assign dy = py - ty_y0;
  assign row_in = dy < POS_W'(e);
  assign row_ok = ({1'b0, ty_y0} + 17'(e) <= {1'b0, h})
               && (all_rows || int'(ty) < MAX_ACTIVE_TILE_ROWS);
  assign col_in = dx < POS_W'(e);
  assign col_ok = (int'(tx) < MAX_TILES_ACROSS)
               && ({1'b0, tx_x0} + 17'(e) <= {1'b0, w});
  assign first_px  = (dx == '0) && (dy == '0);
  assign last_px   = (dx == POS_W'(e) - 1'b1) && (dy == POS_W'(e) - 1'b1);
  assign label_hit = int'(cur_label) < NUM_LABELS;

  assign addr   = AW'(slot) * AW'(MAX_TILES_ACROSS) + AW'(tx[TXW-1:0]);
  assign mem_re = (state == S_COL) && col_in && col_ok;
  assign mem_we = (state == S_RD);

  always_comb begin
    for (int k = 0; k < NUM_LABELS; k++) begin
      cnt_new[k] = first_px ? '0 : rdata[k*COUNT_W +: COUNT_W];
      if (label_hit && cur_label[LW-1:0] == LW'(k)) begin
        cnt_new[k] = cnt_new[k] + 1'b1;
      end
      wdata[k*COUNT_W +: COUNT_W] = cnt_new[k];
    end
  end

  thls_count_ram #(.DEPTH(DEPTH), .WORD_W(WORD_W), .AW(AW)) u_ram (
    .clk   (clk),
    .re    (mem_re),
    .raddr (addr),
    .rdata (rdata),
    .we    (mem_we),
    .waddr (addr),
    .wdata (wdata)
  );

  // most frequent nonzero class, ties to lowest
  logic [CLASS_W-1:0] best_cls;
  logic [COUNT_W-1:0] best_cnt;

  always_comb begin
    best_cls = '0;
    best_cnt = '0;
    for (int k = 1; k < NUM_LABELS; k++) begin
      if (sc_counts[k] > best_cnt) begin
        best_cnt = sc_counts[k];
        best_cls = CLASS_W'(k);
      end
    end
  end

  logic               div_start, div_done, bg_hit;
  logic [COUNT_W-1:0] div_count;
  logic [SHARE_W-1:0] div_q;

  assign bg_hit    = div_q >= background_limit;
  assign div_count = (state == S_FINISH) ? sc_counts[0] : best_cnt;
  assign div_start = ((state == S_FINISH) && pend)
                  || ((state == S_DIV0) && div_done && !bg_hit && best_cnt != '0);

  thls_share_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .count    (div_count),
    .area     (area),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pixel.ready = (state == S_IDLE);

  // step to the tile row above, or finish
  logic next_row_end;
  assign next_row_end = (ty == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= POS_W'(1024);
      image_height     <= POS_W'(1024);
      tile_edge        <= EDGE_W'(512);
      tile_step        <= EDGE_W'(512);
      background_limit <= LIMIT_W'(45875);
      class_limit      <= LIMIT_W'(655);
      pos_x  <= '0;
      pos_y  <= '0;
      base_x <= '0;
      base_y <= '0;
      q_x    <= '0;
      q_y    <= '0;
      rem_x  <= '0;
      rem_y  <= '0;
      slot_y <= '0;
      state  <= S_IDLE;
      pend   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // the emit state handles its own output handshake
      if (result.ready && state != S_EMIT) begin
        result.valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:      image_width      <= cfg_data[POS_W-1:0];
          REG_IMAGE_HEIGHT:     image_height     <= cfg_data[POS_W-1:0];
          REG_TILE_EDGE:        tile_edge        <= cfg_data[EDGE_W-1:0];
          REG_TILE_STEP:        tile_step        <= cfg_data[EDGE_W-1:0];
          REG_BACKGROUND_LIMIT: background_limit <= cfg_data[LIMIT_W-1:0];
          REG_CLASS_LIMIT:      class_limit      <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
        if (int'(cfg_index) <= int'(REG_CLASS_LIMIT)) begin
          pos_x  <= '0;
          pos_y  <= '0;
          base_x <= '0;
          base_y <= '0;
          q_x    <= '0;
          q_y    <= '0;
          rem_x  <= '0;
          rem_y  <= '0;
          slot_y <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            cur_label <= pixel.label;
            px     <= pos_x;
            py     <= pos_y;
            lat_qx <= q_x;
            lat_bx <= base_x;
            ty     <= q_y;
            ty_y0  <= base_y;
            slot   <= slot_y;
            area   <= AREA_W'(e) * AREA_W'(e);
            pend   <= 1'b0;
            state  <= S_ROW;
            // advance scan position
            if ({1'b0, pos_x} + 17'd1 >= {1'b0, w}) begin
              pos_x  <= '0;
              base_x <= '0;
              q_x    <= '0;
              rem_x  <= '0;
              if ({1'b0, pos_y} + 17'd1 >= {1'b0, h}) begin
                pos_y  <= '0;
                base_y <= '0;
                q_y    <= '0;
                rem_y  <= '0;
                slot_y <= '0;
              end else begin
                pos_y <= pos_y + 1'b1;
                if (rem_y + 1'b1 == s) begin
                  rem_y  <= '0;
                  base_y <= pos_y + 1'b1;
                  q_y    <= q_y + 1'b1;
                  slot_y <= (slot_y == SW'(MAX_ACTIVE_TILE_ROWS - 1)) ? '0
                                                                       : slot_y + 1'b1;
                end else begin
                  rem_y <= rem_y + 1'b1;
                end
              end
            end else begin
              pos_x <= pos_x + 1'b1;
              if (rem_x + 1'b1 == s) begin
                rem_x  <= '0;
                base_x <= pos_x + 1'b1;
                q_x    <= q_x + 1'b1;
              end else begin
                rem_x <= rem_x + 1'b1;
              end
            end
          end
        end

        S_ROW: begin
          if (!row_in) begin
            state <= S_FINISH;
          end else if (row_ok) begin
            tx    <= lat_qx;
            tx_x0 <= lat_bx;
            state <= S_COL;
          end else if (next_row_end) begin
            state <= S_FINISH;
          end else begin
            ty    <= ty - 1'b1;
            ty_y0 <= ty_y0 - POS_W'(s);
            slot  <= (slot == '0) ? SW'(MAX_ACTIVE_TILE_ROWS - 1) : slot - 1'b1;
          end
        end

        S_COL: begin
          if (col_in && col_ok) begin
            state <= S_RD;
          end else if (col_in && tx != '0) begin
            tx    <= tx - 1'b1;
            tx_x0 <= tx_x0 - POS_W'(s);
          end else if (next_row_end) begin
            state <= S_FINISH;
          end else begin
            ty    <= ty - 1'b1;
            ty_y0 <= ty_y0 - POS_W'(s);
            slot  <= (slot == '0) ? SW'(MAX_ACTIVE_TILE_ROWS - 1) : slot - 1'b1;
            state <= S_ROW;
          end
        end

        S_RD: begin
          // counts were read last cycle; write back happens this edge
          if (last_px) begin
            pend  <= 1'b1;
            sc_x0 <= tx_x0;
            sc_y0 <= ty_y0;
            for (int k = 0; k < NUM_LABELS; k++) begin
              sc_counts[k] <= cnt_new[k];
            end
          end
          if (tx != '0) begin
            tx    <= tx - 1'b1;
            tx_x0 <= tx_x0 - POS_W'(s);
            state <= S_COL;
          end else if (next_row_end) begin
            state <= S_FINISH;
          end else begin
            ty    <= ty - 1'b1;
            ty_y0 <= ty_y0 - POS_W'(s);
            slot  <= (slot == '0) ? SW'(MAX_ACTIVE_TILE_ROWS - 1) : slot - 1'b1;
            state <= S_ROW;
          end
        end

        S_FINISH: begin
          state <= pend ? S_DIV0 : S_IDLE;
        end

        S_DIV0: begin
          if (div_done) begin
            if (bg_hit) begin
              hold_cls   <= '0;
              hold_share <= div_q;
              state      <= S_EMIT;
            end else if (best_cnt == '0) begin
              state <= S_IDLE;
            end else begin
              state <= S_DIV1;
            end
          end
        end

        S_DIV1: begin
          if (div_done) begin
            if (div_q >= class_limit) begin
              hold_cls   <= best_cls;
              hold_share <= div_q;
              state      <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid      <= 1'b1;
            result.origin_x   <= sc_x0;
            result.origin_y   <= sc_y0;
            result.tile_class <= hold_cls;
            result.share      <= hold_share;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/thls_checker.sv */
// Port-level checks for the tile label histogram scorer, bound to the top.
// Depends on tile_label_histogram_scorer_assert.svh.
`include "tile_label_histogram_scorer_assert.svh"

module thls_checker #(
  parameter int NUM_LABELS = 6
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [2:0]  out_class,
  input logic [16:0] out_share
);

  `THLS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_class) && $stable(out_share), "result item changed while stalled")

  `THLS_ASSERT_IMP(a_class_range, out_valid, int'(out_class) < NUM_LABELS, "class out of range")

  `THLS_ASSERT_IMP(a_share_range, out_valid, out_share <= 17'd65536, "share above one")

  `THLS_ASSERT_RST(a_reset_clear, rst, !out_valid, "result valid after reset")

endmodule

bind tile_label_histogram_scorer thls_checker #(.NUM_LABELS(NUM_LABELS)) u_thls_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_x     (result.origin_x),
  .out_y     (result.origin_y),
  .out_class (result.tile_class),
  .out_share (result.share)
);

/* dv/tile_label_histogram_scorer_checker.sv */
`timescale 1ns / 1ps
// Checker for the tile label histogram scorer: follows config writes and
// accepted pixels, predicts tile results and compares them. Needs thls_pkg, thls_if.
module tile_label_histogram_scorer_checker
  import thls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  thls_in_if                    pixel,
  thls_out_if                   result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    fail_count
);
  localparam int EDGE_CAP  = 512;
  localparam int COLS_CAP  = 128;
  localparam int ROWS_CAP  = 4;
  localparam int LABELS    = 6;

  typedef struct packed {
    logic [POS_W-1:0]   origin_x;
    logic [POS_W-1:0]   origin_y;
    logic [CLASS_W-1:0] tile_class;
    logic [SHARE_W-1:0] share;
  } tile_score_t;

  logic [15:0] img_w, img_h;
  logic [9:0]  edge_len, step_len;
  logic [16:0] bg_limit, cls_limit;
  logic [COUNT_W-1:0] label_count [ROWS_CAP][COLS_CAP][LABELS];
  int unsigned col_pos, row_pos;
  tile_score_t score_q[$];

  assign pending = score_q.size();

  function automatic int unsigned one_if_zero(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned tiles_in(int unsigned len, int unsigned e,
                                           int unsigned s);
    return (len < e) ? 0 : 1 + (len - e) / s;
  endfunction

  function automatic int unsigned share_of(int unsigned cnt, longint unsigned area);
    return int'((longint'(cnt) << 16) / area);
  endfunction

  // walk every tile holding the current pixel; score tiles ending here
  function automatic void score_pixel(logic [LABEL_W-1:0] lbl);
    int unsigned w, h, e, s, x, y, nx, ny, tx_lo, tx_hi, ty_lo, ty_hi;
    int unsigned x0, y0, slot, sh0, sh, best, best_cnt, cls;
    longint unsigned area;
    bit emitted, emit;
    tile_score_t item;
    w = one_if_zero(img_w);
    h = one_if_zero(img_h);
    e = one_if_zero(edge_len);
    if (e > EDGE_CAP) e = EDGE_CAP;
    s = one_if_zero(step_len);
    x = col_pos;
    y = row_pos;
    nx = tiles_in(w, e, s);
    ny = tiles_in(h, e, s);
    area = longint'(e) * e;
    emitted = 0;
    if (nx > COLS_CAP) nx = COLS_CAP;
    if (e > ROWS_CAP * s && ny > ROWS_CAP) ny = ROWS_CAP;
    if (nx > 0 && ny > 0) begin
      tx_lo = (x + 1 >= e) ? (x + 1 - e + s - 1) / s : 0;
      tx_hi = x / s;
      if (tx_hi > nx - 1) tx_hi = nx - 1;
      ty_lo = (y + 1 >= e) ? (y + 1 - e + s - 1) / s : 0;
      ty_hi = y / s;
      if (ty_hi > ny - 1) ty_hi = ny - 1;
      for (int unsigned ty = ty_lo; ty <= ty_hi && ty < ny; ty++) begin
        y0 = ty * s;
        slot = ty % ROWS_CAP;
        for (int unsigned tx = tx_lo; tx <= tx_hi && tx < nx; tx++) begin
          x0 = tx * s;
          if (x == x0 && y == y0)
            for (int k = 0; k < LABELS; k++) label_count[slot][tx][k] = '0;
          if (lbl < LABELS) label_count[slot][tx][lbl] += 1'b1;
          if (x == x0 + e - 1 && y == y0 + e - 1) begin
            sh0 = share_of(label_count[slot][tx][0], area);
            emit = 0;
            cls = 0;
            sh = 0;
            if (sh0 >= bg_limit) begin
              emit = 1;
              sh = sh0;
            end else begin
              best = 0;
              best_cnt = 0;
              for (int k = 1; k < LABELS; k++)
                if (label_count[slot][tx][k] > best_cnt) begin
                  best_cnt = label_count[slot][tx][k];
                  best = k;
                end
              if (best != 0) begin
                sh = share_of(best_cnt, area);
                if (sh >= cls_limit) begin
                  emit = 1;
                  cls = best;
                end
              end
            end
            if (emit && !emitted) begin
              item.origin_x = x0[15:0];
              item.origin_y = y0[15:0];
              item.tile_class = cls[2:0];
              item.share = sh[16:0];
              score_q.push_back(item);
              emitted = 1;
            end
          end
        end
      end
    end
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  always @(posedge clk) begin
    tile_score_t exp_item;
    if (rst) begin
      img_w = 16'd1024;
      img_h = 16'd1024;
      edge_len = 10'd512;
      step_len = 10'd512;
      bg_limit = 17'd45875;
      cls_limit = 17'd655;
      col_pos = 0;
      row_pos = 0;
      score_q.delete();
      fail_count = 0;
      foreach (label_count[i, j, k]) label_count[i][j][k] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:      img_w = cfg_data[15:0];
          REG_IMAGE_HEIGHT:     img_h = cfg_data[15:0];
          REG_TILE_EDGE:        edge_len = cfg_data[9:0];
          REG_TILE_STEP:        step_len = cfg_data[9:0];
          REG_BACKGROUND_LIMIT: bg_limit = cfg_data;
          REG_CLASS_LIMIT:      cls_limit = cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_CLASS_LIMIT) begin
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (pixel.valid && pixel.ready) score_pixel(pixel.label);
      if (result.valid && result.ready) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d class=%0d share=%0d", $time,
                   result.origin_x, result.origin_y, result.tile_class, result.share);
          fail_count++;
        end else begin
          exp_item = score_q.pop_front();
          if (result.origin_x !== exp_item.origin_x) begin
            $display("%0t: origin_x expected %0d actual %0d", $time,
                     exp_item.origin_x, result.origin_x);
            fail_count++;
          end
          if (result.origin_y !== exp_item.origin_y) begin
            $display("%0t: origin_y expected %0d actual %0d", $time,
                     exp_item.origin_y, result.origin_y);
            fail_count++;
          end
          if (result.tile_class !== exp_item.tile_class) begin
            $display("%0t: tile_class expected %0d actual %0d", $time,
                     exp_item.tile_class, result.tile_class);
            fail_count++;
          end
          if (result.share !== exp_item.share) begin
            $display("%0t: share expected %0d actual %0d", $time,
                     exp_item.share, result.share);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

/* dv/tb_tile_label_histogram_scorer.sv */
`timescale 1ns / 1ps
// Top of the tile label histogram scorer bench: clock, reset, pixel and
// config stimulus, result stalls and verdict. Needs thls_pkg, thls_if, the checker.
module tb_tile_label_histogram_scorer;
  import thls_pkg::*;

  localparam int SETTLE_CYCLES = 300;

  logic clk = 0;
  logic rst = 1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int pending, fail_count;
  int burst_left = 0;
  int random_items = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  thls_in_if  pix_if();
  thls_out_if res_if();

  always #1 clk = ~clk;

  tile_label_histogram_scorer u_dut (
    .clk(clk), .rst(rst), .pixel(pix_if), .result(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tile_label_histogram_scorer_checker u_checker (
    .clk(clk), .rst(rst), .pixel(pix_if), .result(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  // result stalls: free-running, random, periodic, or sparse random; mode changes now and then
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(50, 600);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= $urandom_range(0, 1);
      2: res_if.ready <= (stall_phase % 4 == 0);
      default: res_if.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_label(input logic [LABEL_W-1:0] lbl);
    if (burst_left == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    pix_if.valid <= 1'b1;
    pix_if.label <= lbl;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain;
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h, input int e, input int s,
                              input int bg, input int cl);
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_TILE_EDGE, CFG_DATA_W'(e));
    write_reg(REG_TILE_STEP, CFG_DATA_W'(s));
    write_reg(REG_BACKGROUND_LIMIT, CFG_DATA_W'(bg));
    write_reg(REG_CLASS_LIMIT, CFG_DATA_W'(cl));
    // indexes past the register list must be harmless
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(int'(REG_CLASS_LIMIT) + 1 + $urandom_range(0, 1)),
                CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return 45875;
      4: return 655;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label(input int lead);
    if ($urandom_range(0, 9) < 6)
      return (lead > 5) ? LABEL_W'($urandom_range(6, 255)) : LABEL_W'(lead);
    if ($urandom_range(0, 1)) return LABEL_W'($urandom_range(0, 255));
    return LABEL_W'($urandom_range(0, 5));
  endfunction

  initial begin
    int w, h, e, s, lead, n;
    pix_if.valid <= 1'b0;
    pix_if.label <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sizes act as one: every pixel is its own tile, background always wins
    set_geometry(2, 2, 0, 0, 0, 0);
    send_label(8'd0); send_label(8'd255); send_label(8'd5); send_label(8'd3);
    // overlapping 2x2 tiles, background out of reach, ties go to the lower class
    set_geometry(3, 3, 2, 1, 65536, 0);
    send_label(8'd2); send_label(8'd1); send_label(8'd0);
    send_label(8'd1); send_label(8'd2); send_label(8'd4);
    send_label(8'd0); send_label(8'd0); send_label(8'd0);
    // oversized tile on the largest image, thresholds never reached
    set_geometry(65535, 65535, 1023, 512, 131071, 131071);
    send_label(8'd1); send_label(8'd6); send_label(8'd0);
    // image smaller than one tile, then wraparound into the next image
    set_geometry(2, 1, 4, 1, 0, 0);
    send_label(8'd0); send_label(8'd3); send_label(8'd0);
    // full-size reach: class threshold exactly one tile
    set_geometry(2, 2, 2, 2, 65536, 65536);
    send_label(8'd4); send_label(8'd4); send_label(8'd4); send_label(8'd4);

    while (random_items < 450) begin
      case ($urandom_range(0, 7))
        0: begin  // more tile columns than the block tracks
          w = $urandom_range(129, 134); h = $urandom_range(1, 2); e = 1; s = 1;
        end
        1: begin  // more overlapping tile rows than slots
          w = $urandom_range(5, 7); h = $urandom_range(8, 10);
          e = $urandom_range(5, 6); s = 1;
        end
        default: begin
          w = $urandom_range(1, 12); h = $urandom_range(1, 12);
          e = $urandom_range(0, 6); s = $urandom_range(0, 5);
        end
      endcase
      set_geometry(w, h, e, s, pick_limit(), pick_limit());
      lead = $urandom_range(0, 7);
      n = w * h + $urandom_range(0, w * h);
      if (n > 300) n = w * h;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) == 0) drain();
        if ($urandom_range(0, 19) == 0) lead = $urandom_range(0, 7);
        send_label(pick_label(lead));
        random_items++;
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/thls_pkg.sv
rtl/thls_if.sv
rtl/thls_count_ram.sv
rtl/thls_share_div.sv
rtl/tile_label_histogram_scorer.sv
rtl/thls_checker.sv
dv/tile_label_histogram_scorer_checker.sv
dv/tb_tile_label_histogram_scorer.sv
